// ===== hw/rtl/event_queue_fifo_lifo_defines.svh =====
// Assertion macros used by the event queue RTL.
`ifndef EVENT_QUEUE_FIFO_LIFO_DEFINES_SVH
`define EVENT_QUEUE_FIFO_LIFO_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define EQFL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define EQFL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/eqfl_pkg.sv =====
// Types and constants of the event queue.
package eqfl_pkg;

  localparam int EventBits = 8;
  localparam int LenBits   = 5;
  localparam int RingDepth = 16;

  localparam logic [1:0] FUNC_POST_BACK  = 2'd0;
  localparam logic [1:0] FUNC_POST_FRONT = 2'd1;
  localparam logic [1:0] FUNC_TAKE       = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]           func;
    logic [EventBits-1:0] event_id;
  } req_t;

  typedef struct packed {
    logic [EventBits-1:0] event_out;
    logic                 event_valid;
    logic                 notify;
    logic [1:0]           status;
    logic [LenBits-1:0]   free_count;
    logic [LenBits-1:0]   min_free;
  } res_t;

endpackage

// ===== hw/rtl/eqfl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module eqfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/event_queue_fifo_lifo.sv =====
// Event queue with a front slot and a ring in RAM, posting at back or front.
//
// Usage: a request word (func, event_id) on req_i is taken at a rising edge
// where start is high and busy is low. Func selects post at back, post at
// front or take. Every request gives one result word on res_o, marked by
// res_strobe_o for exactly one cycle; the receiver cannot hold it off.
// In the cycle after a request is taken, busy is high while the RAM read
// data at the tail pointer arrives and the update is computed and written
// back. The result shows in the cycle after that, when busy is already
// low again and a new request can be taken. The strobe and the result
// word are both registered at the end of the busy cycle.
// The ring length register is written over cfg_data_i when cfg_valid_i and
// cfg_ready_o are both high; a write empties the queue and restarts the
// free count watermark. cfg_ready_o is high whenever busy is low. A request
// taken at the same edge as a write is served after the write.
// After reset the queue is empty, the ring length is the smaller of the ring
// depth and sixteen, and the RAM contents are unknown until written.
`include "event_queue_fifo_lifo_defines.svh"

module event_queue_fifo_lifo #(
  parameter int RING_DEPTH = eqfl_pkg::RingDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  eqfl_pkg::req_t               req_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [eqfl_pkg::LenBits-1:0] cfg_data_i,
  output logic                         res_strobe_o,
  output eqfl_pkg::res_t               res_o
);

  localparam int LenW   = eqfl_pkg::LenBits;
  localparam int CntW   = LenW + 1;
  localparam int EvW    = eqfl_pkg::EventBits;
  localparam int PtrW   = RING_DEPTH > 1 ? $clog2(RING_DEPTH) : 1;
  localparam int CmpW   = (PtrW > LenW ? PtrW : LenW) + 1;
  localparam int MaxLen = RING_DEPTH < 31 ? RING_DEPTH : 31;
  localparam int RstLen = RING_DEPTH < 16 ? RING_DEPTH : 16;
  localparam logic [LenW-1:0] MaxLenV = LenW'(MaxLen);
  localparam logic [LenW-1:0] RstLenV = LenW'(RstLen);

  logic                busy_q;
  eqfl_pkg::req_t      req_q;
  logic [LenW-1:0]     len_q;
  logic [EvW-1:0]      front_q, front_d;
  logic                full_q, full_d;
  logic [PtrW-1:0]     head_q, head_d;
  logic [PtrW-1:0]     tail_q, tail_d;
  logic [CntW-1:0]     free_q, free_d;
  logic [CntW-1:0]     low_q, low_d;
  logic                strobe_q;
  eqfl_pkg::res_t      res_q, res_d;

  logic                ram_we;
  logic [PtrW-1:0]     ram_waddr;
  logic [EvW-1:0]      ram_wdata;
  logic [EvW-1:0]      ram_rdata;

  logic [LenW-1:0]     cfg_len;
  logic [CmpW-1:0]     tail_inc;
  logic [PtrW-1:0]     tail_up;
  logic [PtrW-1:0]     last_idx;
  logic [CntW-1:0]     free_dec;
  logic [CntW-1:0]     free_inc;
  logic                accept;
  logic                cfg_we;

  assign accept      = start && !busy_q;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign busy        = busy_q;
  assign cfg_ready_o = !busy_q;
  assign res_strobe_o = strobe_q;
  assign res_o       = res_q;

  always_comb begin
    cfg_len = cfg_data_i;
    if (cfg_len == '0) begin
      cfg_len = LenW'(1);
    end
    if (cfg_len > MaxLenV) begin
      cfg_len = MaxLenV;
    end
  end

  assign last_idx = PtrW'(len_q - LenW'(1));
  assign tail_inc = CmpW'(tail_q) + CmpW'(1);
  assign tail_up  = (tail_inc >= CmpW'(len_q)) ? '0 : PtrW'(tail_inc);
  assign free_dec = free_q - CntW'(1);
  assign free_inc = free_q + CntW'(1);

  eqfl_ram #(
    .WIDTH(EvW),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(tail_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    front_d   = front_q;
    full_d    = full_q;
    head_d    = head_q;
    tail_d    = tail_q;
    free_d    = free_q;
    low_d     = low_q;
    ram_we    = 1'b0;
    ram_waddr = head_q;
    ram_wdata = req_q.event_id;
    res_d     = '0;
    res_d.status = eqfl_pkg::STATUS_OK;

    case (req_q.func) inside
      eqfl_pkg::FUNC_POST_BACK, eqfl_pkg::FUNC_POST_FRONT: begin
        if (free_q == '0) begin
          res_d.status = eqfl_pkg::STATUS_FULL;
        end else begin
          free_d = free_dec;
          if (free_dec < low_q) begin
            low_d = free_dec;
          end
          if (!full_q) begin
            front_d      = req_q.event_id;
            full_d       = 1'b1;
            res_d.notify = 1'b1;
          end else if (req_q.func == eqfl_pkg::FUNC_POST_BACK) begin
            ram_we    = 1'b1;
            ram_waddr = head_q;
            ram_wdata = req_q.event_id;
            head_d    = (head_q == '0) ? last_idx : head_q - PtrW'(1);
          end else begin
            ram_we    = 1'b1;
            ram_waddr = tail_up;
            ram_wdata = front_q;
            tail_d    = tail_up;
            front_d   = req_q.event_id;
          end
        end
      end
      eqfl_pkg::FUNC_TAKE: begin
        if (!full_q) begin
          res_d.status = eqfl_pkg::STATUS_EMPTY;
        end else begin
          res_d.event_out   = front_q;
          res_d.event_valid = 1'b1;
          if (free_inc <= CntW'(len_q)) begin
            free_d  = free_inc;
            front_d = ram_rdata;
            tail_d  = (tail_q == '0) ? last_idx : tail_q - PtrW'(1);
          end else begin
            front_d = '0;
            full_d  = 1'b0;
            free_d  = CntW'(len_q) + CntW'(1);
          end
        end
      end
      default: begin
      end
    endcase

    res_d.free_count = free_d[LenW-1:0];
    res_d.min_free   = low_d[LenW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      strobe_q <= 1'b0;
      len_q    <= RstLenV;
      front_q  <= '0;
      full_q   <= 1'b0;
      head_q   <= '0;
      tail_q   <= '0;
      free_q   <= CntW'(RstLenV) + CntW'(1);
      low_q    <= CntW'(RstLenV) + CntW'(1);
    end else begin
      strobe_q <= busy_q;
      if (busy_q) begin
        busy_q  <= 1'b0;
        front_q <= front_d;
        full_q  <= full_d;
        head_q  <= head_d;
        tail_q  <= tail_d;
        free_q  <= free_d;
        low_q   <= low_d;
      end else if (cfg_we) begin
        busy_q  <= accept;
        len_q   <= cfg_len;
        front_q <= '0;
        full_q  <= 1'b0;
        head_q  <= '0;
        tail_q  <= '0;
        free_q  <= CntW'(cfg_len) + CntW'(1);
        low_q   <= CntW'(cfg_len) + CntW'(1);
      end else if (accept) begin
        busy_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (busy_q) begin
      res_q <= res_d;
    end
  end

  `EQFL_ASSERT_NOW(a_strobe_idle, res_strobe_o, !busy)
  `EQFL_ASSERT_NEXT(a_busy_one_cycle, busy, !busy && res_strobe_o)
  `EQFL_ASSERT_NEXT(a_accept_busy, start && !busy && !cfg_valid_i, busy)
  `EQFL_ASSERT_NOW(a_take_ok, res_strobe_o && res_o.event_valid, res_o.status == eqfl_pkg::STATUS_OK)
  `EQFL_ASSERT_NOW(a_free_bound, 1'b1, free_q <= CntW'(len_q) + CntW'(1) && low_q <= free_q)

endmodule

// ===== verif/eqfl_checker.sv =====
// Checker for the event queue: predicts each request's result word and compares it.
`timescale 1ns / 1ps

module eqfl_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  input  logic                         busy,
  input  eqfl_pkg::req_t               req_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_o,
  input  logic [eqfl_pkg::LenBits-1:0] cfg_data_i,
  input  logic                         res_strobe_o,
  input  eqfl_pkg::res_t               res_o,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           checked_o,
  output int                           full_seen_o,
  output int                           empty_seen_o
);
  import eqfl_pkg::*;

  localparam int MaxReports = 10;

  int                   ring_len;
  logic [EventBits-1:0] front_event;
  logic                 front_full;
  logic [EventBits-1:0] ring_store [RingDepth];
  int                   head_index;
  int                   tail_index;
  int                   free_places;
  int                   lowest_free;
  res_t                 expected_words [$];

  function automatic void empty_queue();
    front_event = '0;
    front_full  = 1'b0;
    head_index  = 0;
    tail_index  = 0;
    free_places = ring_len + 1;
    lowest_free = ring_len + 1;
  endfunction

  function automatic void set_ring_length(logic [LenBits-1:0] value);
    int v;
    v = int'(value);
    if (v < 1) v = 1;
    if (v > RingDepth) v = RingDepth;
    ring_len = v;
    empty_queue();
  endfunction

  function automatic res_t serve_request(req_t r);
    res_t o;
    o = '0;
    o.status = STATUS_OK;
    case (r.func)
      FUNC_POST_BACK, FUNC_POST_FRONT: begin
        if (free_places == 0) begin
          o.status = STATUS_FULL;
        end else begin
          free_places--;
          if (lowest_free > free_places) lowest_free = free_places;
          if (!front_full) begin
            front_event = r.event_id;
            front_full  = 1'b1;
            o.notify    = 1'b1;
          end else if (r.func == FUNC_POST_BACK) begin
            ring_store[head_index] = r.event_id;
            if (head_index == 0) head_index = ring_len;
            head_index--;
          end else begin
            tail_index++;
            if (tail_index >= ring_len) tail_index = 0;
            ring_store[tail_index] = front_event;
            front_event = r.event_id;
          end
        end
      end
      FUNC_TAKE: begin
        if (!front_full) begin
          o.status = STATUS_EMPTY;
        end else begin
          o.event_out   = front_event;
          o.event_valid = 1'b1;
          free_places++;
          if (free_places <= ring_len) begin
            front_event = ring_store[tail_index];
            if (tail_index == 0) tail_index = ring_len;
            tail_index--;
          end else begin
            front_event = '0;
            front_full  = 1'b0;
            free_places = ring_len + 1;
          end
        end
      end
      default: ;
    endcase
    o.free_count = LenBits'(free_places);
    o.min_free   = LenBits'(lowest_free);
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    res_t got;
    logic bad;
    if (!rst_ni) begin
      ring_len = (RingDepth < 16) ? RingDepth : 16;
      empty_queue();
      expected_words.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      full_seen_o  = 0;
      empty_seen_o = 0;
    end else begin
      if (res_strobe_o) begin
        got = res_o;
        if (expected_words.size() == 0) begin
          if (fail_count_o < MaxReports)
            $display("Unexpected result word: ev=%0d valid=%0d notify=%0d status=%0d free=%0d min=%0d",
                     got.event_out, got.event_valid, got.notify, got.status,
                     got.free_count, got.min_free);
          fail_count_o++;
        end else begin
          want = expected_words.pop_front();
          bad = (got.event_out !== want.event_out) || (got.event_valid !== want.event_valid) ||
                (got.notify !== want.notify) || (got.status !== want.status) ||
                (got.free_count !== want.free_count) || (got.min_free !== want.min_free);
          if (bad) begin
            if (fail_count_o < MaxReports)
              $display("Mismatch: expected ev=%0d valid=%0d notify=%0d status=%0d free=%0d min=%0d, got ev=%0d valid=%0d notify=%0d status=%0d free=%0d min=%0d",
                       want.event_out, want.event_valid, want.notify, want.status,
                       want.free_count, want.min_free, got.event_out, got.event_valid,
                       got.notify, got.status, got.free_count, got.min_free);
            fail_count_o++;
          end
          checked_o++;
        end
      end
      if (cfg_valid_i && cfg_ready_o) set_ring_length(cfg_data_i);
      if (start && !busy) begin
        want = serve_request(req_i);
        if (want.status == STATUS_FULL) full_seen_o++;
        if (want.status == STATUS_EMPTY) empty_seen_o++;
        expected_words.push_back(want);
      end
      pending_o = expected_words.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the event queue: clock, reset, request and ring length stimulus, verdict.
`timescale 1ns / 1ps

module tb;
  import eqfl_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int NumPhases     = 10;
  localparam int ItemsPerPhase = 200;
  localparam int CycleLimit    = 300000;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start       = 1'b0;
  logic                 busy;
  req_t                 req_i       = '0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [LenBits-1:0]   cfg_data_i  = '0;
  logic                 res_strobe_o;
  res_t                 res_o;

  int fail_count;
  int pending;
  int checked;
  int full_seen;
  int empty_seen;
  int cycle_count = 0;
  int func_sent [4];
  int cfg_writes;

  event_queue_fifo_lifo u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o)
  );

  eqfl_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .full_seen_o (full_seen),
    .empty_seen_o(empty_seen)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d words outstanding", cycle_count, pending);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_request(logic [1:0] func, logic [EventBits-1:0] ev);
    logic taken;
    start <= 1'b1;
    req_i <= '{func: func, event_id: ev};
    func_sent[func]++;
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_ring_length(logic [LenBits-1:0] value);
    logic taken;
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    cfg_writes++;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int                   len;
    int                   roll;
    int                   post_odds;
    int                   gap_odds;
    logic [1:0]           func;
    logic [EventBits-1:0] ev;

    cfg_writes = 0;
    foreach (func_sent[i]) func_sent[i] = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset ring length.
    send_request(FUNC_TAKE, 8'h00);
    send_request(FUNC_UNUSED, 8'hFF);
    send_request(FUNC_POST_BACK, 8'h00);
    send_request(FUNC_POST_BACK, 8'hFF);
    send_request(FUNC_POST_FRONT, 8'hA5);
    send_request(FUNC_POST_FRONT, 8'h5A);
    send_request(FUNC_UNUSED, 8'h00);
    send_request(FUNC_TAKE, 8'hFF);
    send_request(FUNC_TAKE, 8'h00);
    send_request(FUNC_TAKE, 8'h00);
    send_request(FUNC_TAKE, 8'h00);
    send_request(FUNC_TAKE, 8'h00);

    // Directed part at the shortest ring.
    write_ring_length(5'd1);
    send_request(FUNC_POST_FRONT, 8'h11);
    send_request(FUNC_POST_BACK, 8'h22);
    send_request(FUNC_POST_BACK, 8'h33);
    send_request(FUNC_POST_FRONT, 8'h44);
    send_request(FUNC_TAKE, 8'h00);
    send_request(FUNC_POST_FRONT, 8'h55);
    send_request(FUNC_TAKE, 8'h00);
    send_request(FUNC_TAKE, 8'h00);
    send_request(FUNC_TAKE, 8'h00);

    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0:       len = 16;
        1:       len = 0;
        2:       len = 31;
        3:       len = 1;
        default: len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
      endcase
      write_ring_length(LenBits'(len));
      gap_odds = (phase == NumPhases - 1 || phase % 3 == 0) ? 0 : $urandom_range(4, 10);
      for (int k = 0; k < ItemsPerPhase; k++) begin
        post_odds = ((k / 40) % 2 == 0) ? 80 : 22;
        roll = $urandom_range(0, 99);
        if (roll < 3) func = FUNC_UNUSED;
        else if (roll < post_odds) func = $urandom_range(0, 1) ? FUNC_POST_FRONT : FUNC_POST_BACK;
        else func = FUNC_TAKE;
        ev = $urandom_range(0, 255);
        send_request(func, ev);
        if (phase == 4 && k == ItemsPerPhase / 2) wait_drained();
        else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
          pause_sender($urandom_range(1, 18));
      end
    end

    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d back posts, %0d front posts, %0d takes and %0d unused codes over %0d ring length writes.",
             func_sent[FUNC_POST_BACK], func_sent[FUNC_POST_FRONT], func_sent[FUNC_TAKE],
             func_sent[FUNC_UNUSED], cfg_writes);
    $display("Checked %0d result words, %0d full refusals and %0d empty takes among them.",
             checked, full_seen, empty_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/eqfl_pkg.sv
hw/rtl/eqfl_ram.sv
hw/rtl/event_queue_fifo_lifo.sv
verif/eqfl_checker.sv
verif/tb.sv
